// ----- hw/rtl/btc_pkg.sv -----
`default_nettype none
package btc_pkg;

   localparam int MAX_ROWS   = 8;
   localparam int MAX_COLS   = 8;
   localparam int CELL_DEPTH = MAX_ROWS * MAX_COLS;
   localparam int MAX_DIM    = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
   localparam int DIM_W      = $clog2(MAX_DIM + 1);
   localparam int PROD_W     = 2 * DIM_W;
   localparam int CELL_W     = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;
   localparam int CNT_W      = $clog2(CELL_DEPTH + 1);

   localparam int NUM_BANKS  = 2;
   localparam int BANK_W     = 1;
   localparam int RAM_AW     = CELL_W + BANK_W;
   localparam int RAM_DEPTH  = NUM_BANKS * (1 << CELL_W);

   localparam int CHAR_W     = 8;
   localparam int DIMREG_W   = 4;
   localparam int PAD_W      = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] REG_ROWS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_COLS = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_MODE = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_PAD  = CSR_IDX_W'(3);

   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   typedef struct packed {
      logic [DIM_W-1:0] nr;
      logic [DIM_W-1:0] nc;
      logic             mode;
      logic [PAD_W-1:0] pad;
   } cfg_type;

   typedef struct packed {
      logic [BANK_W-1:0] bank;
      logic [CELL_W-1:0] last_pos;
      logic              last;
   } desc_type;

   typedef struct packed {
      logic              valid;
      logic [BANK_W-1:0] bank;
   } release_type;

   typedef struct packed {
      logic              en;
      logic [RAM_AW-1:0] addr;
      logic [CHAR_W-1:0] data;
   } ram_wr_type;

   typedef struct packed {
      logic [CHAR_W-1:0] char_out;
      logic              block_end;
      logic              message_end;
   } out_type;

   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIMREG_W-1:0] v,
                                                input int maxv);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (int'(v) > maxv) begin
         r = DIM_W'(maxv);
      end else begin
         r = DIM_W'(v);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/btc_if.sv -----
`default_nettype none
interface btc_req_if
   import btc_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_in;
   logic              last_in;

   modport source (output valid, output char_in, output last_in, input ready);
   modport sink   (input valid, input char_in, input last_in, output ready);
endinterface

interface btc_rsp_if
   import btc_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_out;
   logic              block_end;
   logic              message_end;

   modport source (output valid, output char_out, output block_end,
                   output message_end, input ready);
   modport sink   (input valid, input char_out, input block_end,
                   input message_end, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/btc_ram.sv -----
`default_nettype none
module btc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ----- hw/rtl/btc_front.sv -----
`default_nettype none
module btc_front
   import btc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   btc_req_if.sink          req_if,
   output ram_wr_type       ram_wr,
   output logic             push_valid,
   output desc_type         push_desc,
   input  wire release_type rel
);
   logic [CNT_W-1:0]     fill_ff, fill_in;
   logic [BANK_W-1:0]    wb_ff, wb_in;
   logic [NUM_BANKS-1:0] busy_ff, busy_in;

   logic [CNT_W-1:0]  size;
   logic [CNT_W-1:0]  pos;
   logic [CNT_W-1:0]  pos_inc;
   logic [CELL_W-1:0] last_pos;
   logic              accept;
   logic              done;

   assign size     = CNT_W'(cfg.nr) * CNT_W'(cfg.nc);
   // a block shrunk by a config change lands the byte in its last cell
   assign pos      = (fill_ff >= size) ? (size - CNT_W'(1)) : fill_ff;
   assign pos_inc  = pos + CNT_W'(1);
   assign last_pos = pos[CELL_W-1:0];
   assign done     = (pos_inc == size) || req_if.last_in;

   assign req_if.ready = !busy_ff[wb_ff];
   assign accept       = req_if.valid && req_if.ready;

   assign ram_wr.en   = accept;
   assign ram_wr.addr = {wb_ff, last_pos};
   assign ram_wr.data = req_if.char_in;

   assign push_valid         = accept && done;
   assign push_desc.bank     = wb_ff;
   assign push_desc.last_pos = last_pos;
   assign push_desc.last     = req_if.last_in;

   always_comb begin
      fill_in = fill_ff;
      wb_in   = wb_ff;
      busy_in = busy_ff;
      if (rel.valid) begin
         busy_in[rel.bank] = 1'b0;
      end
      if (accept) begin
         if (done) begin
            fill_in        = '0;
            wb_in          = ~wb_ff;
            busy_in[wb_ff] = 1'b1;
         end else begin
            fill_in = pos_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         wb_ff   <= '0;
         busy_ff <= '0;
      end else begin
         fill_ff <= fill_in;
         wb_ff   <= wb_in;
         busy_ff <= busy_in;
      end
   end
endmodule
`default_nettype wire

// ----- hw/rtl/btc_queue.sv -----
`default_nettype none
module btc_queue
   import btc_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push_valid,
   input  wire desc_type push_desc,
   input  wire logic     pop,
   output logic          q_valid,
   output desc_type      q_desc
);
   desc_type    entry_ff [NUM_BANKS];
   logic        head_ff, head_in;
   logic [1:0]  count_ff, count_in;
   logic        wr_idx;

   assign q_valid = (count_ff != 2'd0);
   assign q_desc  = entry_ff[head_ff];
   assign wr_idx  = head_ff ^ count_ff[0];

   always_comb begin
      head_in  = pop ? ~head_ff : head_ff;
      count_in = count_ff + 2'(push_valid) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_idx] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end
endmodule
`default_nettype wire

// ----- hw/rtl/btc_back.sv -----
`default_nettype none
module btc_back
   import btc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   input  wire logic        q_valid,
   input  wire desc_type    q_desc,
   output logic             q_pop,
   output logic             rd_en,
   output logic [RAM_AW-1:0] rd_addr,
   input  wire logic [CHAR_W-1:0] rd_data,
   output release_type      rel,
   btc_rsp_if.source        rsp_if
);
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic             state_ff, state_in;
   logic [DIM_W-1:0] a_ff, a_in;
   logic [DIM_W-1:0] b_ff, b_in;
   desc_type         desc_ff, desc_in;

   logic             infl_ff;
   logic             infl_pad_ff, infl_be_ff, infl_me_ff;
   out_type          ob_ff [2];
   logic             head_ff, head_in;
   logic [1:0]       count_ff, count_in;

   logic [DIM_W-1:0]  outer, inner;
   logic [PROD_W-1:0] prod;
   logic [CELL_W-1:0] idx;
   logic              a_last, b_last, blk_end;
   logic              pop_out, room, issue;
   logic [2:0]        occ;
   out_type           land;

   // encode walks columns outer, decode walks rows outer; stride equals outer count
   assign outer   = (cfg.mode == MODE_DECODE) ? cfg.nr : cfg.nc;
   assign inner   = (cfg.mode == MODE_DECODE) ? cfg.nc : cfg.nr;
   assign prod    = PROD_W'(b_ff) * PROD_W'(outer);
   assign idx     = CELL_W'(prod + PROD_W'(a_ff));
   assign a_last  = (a_ff == outer - DIM_W'(1));
   assign b_last  = (b_ff == inner - DIM_W'(1));
   assign blk_end = a_last && b_last;

   assign pop_out = rsp_if.valid && rsp_if.ready;
   // buffer entries after this pop plus the read still in flight
   assign occ     = 3'(count_ff) + 3'(infl_ff) - 3'(pop_out);
   assign room    = (occ < 3'd2);
   assign issue   = (state_ff == ST_RUN) && room;

   assign rd_en   = issue;
   assign rd_addr = {desc_ff.bank, idx};

   assign rel.valid = issue && blk_end;
   assign rel.bank  = desc_ff.bank;

   assign q_pop = q_valid && ((state_ff == ST_IDLE) || (issue && blk_end));

   always_comb begin
      state_in = state_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      desc_in  = desc_ff;
      if (q_pop) begin
         state_in = ST_RUN;
         a_in     = '0;
         b_in     = '0;
         desc_in  = q_desc;
      end else if (issue) begin
         if (blk_end) begin
            state_in = ST_IDLE;
         end else if (b_last) begin
            b_in = '0;
            a_in = a_ff + DIM_W'(1);
         end else begin
            b_in = b_ff + DIM_W'(1);
         end
      end
   end

   // cells past the last written one read as the pad byte
   assign land.char_out    = infl_pad_ff ? cfg.pad : rd_data;
   assign land.block_end   = infl_be_ff;
   assign land.message_end = infl_me_ff;

   always_comb begin
      head_in  = pop_out ? ~head_ff : head_ff;
      count_in = count_ff + 2'(infl_ff) - 2'(pop_out);
   end

   assign rsp_if.valid       = (count_ff != 2'd0);
   assign rsp_if.char_out    = ob_ff[head_ff].char_out;
   assign rsp_if.block_end   = ob_ff[head_ff].block_end;
   assign rsp_if.message_end = ob_ff[head_ff].message_end;

   always_ff @(posedge clock) begin
      desc_ff     <= desc_in;
      infl_pad_ff <= (idx > desc_ff.last_pos);
      infl_be_ff  <= blk_end;
      infl_me_ff  <= blk_end && desc_ff.last;
      if (infl_ff) begin
         ob_ff[head_ff ^ count_ff[0]] <= land;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         a_ff     <= '0;
         b_ff     <= '0;
         infl_ff  <= 1'b0;
         head_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         a_ff     <= a_in;
         b_ff     <= b_in;
         infl_ff  <= issue;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("output buffer over capacity");

   a_land_room: assert property (@(posedge clock) disable iff (reset)
      infl_ff |-> (count_ff != 2'd2 || pop_out))
      else $error("read data landed on a full output buffer");

   a_issue_lands: assert property (@(posedge clock) disable iff (reset)
      issue |=> infl_ff)
      else $error("issued read did not land");

   a_release_run: assert property (@(posedge clock) disable iff (reset)
      rel.valid |=> (state_ff == ST_IDLE || (a_ff == '0 && b_ff == '0)))
      else $error("block walk did not restart after release");
`endif
endmodule
`default_nettype wire

// ----- hw/rtl/block_transposition_cipher.sv -----
`default_nettype none
// Rectangular block transposition of a byte stream.
// req_if takes one byte per transaction with last_in marking the end of a
// message; rsp_if returns the permuted bytes with block_end on the final byte
// of each block and message_end on the final byte of a message.
// Bytes fill a block of rows x cols cells; encode reads it out by columns,
// decode by rows. A block goes out when full or when its last byte arrives,
// and unfilled cells of a final block read as pad_byte.
// csr_* writes rows, cols, mode and pad_byte (indexes 0 to 3); these are to be
// written only while idle, which the block itself does not enforce.
// Throughput: up to one byte per cycle each way. The RAM holds two banks:
// the input fills one block while the output reads the other. A bank frees
// after its last cell is read, so the input can wait on a bank even with a
// ready receiver. With the output side idle, a completed block's first byte
// goes through the queue, walker start, RAM read and output buffer registers.
// A stalled receiver holds the two-entry output buffer; reads pause and the
// input keeps running until both banks are taken.
// Reset: registers go to rows 1, cols 1, encode, pad 0; the block is empty.
// The RAM is not cleared, since only written or padded cells are read.
module block_transposition_cipher
   import btc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   btc_req_if.sink                    req_if,
   btc_rsp_if.source                  rsp_if,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wr_data
);
   logic [DIMREG_W-1:0] rows_ff, cols_ff;
   logic                mode_ff;
   logic [PAD_W-1:0]    pad_ff;

   cfg_type     cfg;
   ram_wr_type  ram_wr;
   release_type rel;
   desc_type    push_desc, q_desc;
   logic        push_valid, q_valid, q_pop;
   logic        rd_en;
   logic [RAM_AW-1:0] rd_addr;
   logic [CHAR_W-1:0] rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= DIMREG_W'(1);
         cols_ff <= DIMREG_W'(1);
         mode_ff <= MODE_ENCODE;
         pad_ff  <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_ROWS: rows_ff <= csr_wr_data[DIMREG_W-1:0];
            REG_COLS: cols_ff <= csr_wr_data[DIMREG_W-1:0];
            REG_MODE: mode_ff <= csr_wr_data[0];
            REG_PAD:  pad_ff  <= csr_wr_data[PAD_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.nr   = eff_dim(rows_ff, MAX_ROWS);
   assign cfg.nc   = eff_dim(cols_ff, MAX_COLS);
   assign cfg.mode = mode_ff;
   assign cfg.pad  = pad_ff;

   btc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_if     (req_if),
      .ram_wr     (ram_wr),
      .push_valid (push_valid),
      .push_desc  (push_desc),
      .rel        (rel)
   );

   btc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_desc  (push_desc),
      .pop        (q_pop),
      .q_valid    (q_valid),
      .q_desc     (q_desc)
   );

   btc_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr.en),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   btc_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .q_valid (q_valid),
      .q_desc  (q_desc),
      .q_pop   (q_pop),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .rel     (rel),
      .rsp_if  (rsp_if)
   );
endmodule
`default_nettype wire

// ----- bench/tb_block_transposition_cipher.sv -----
`timescale 1ns / 1ps
module tb_block_transposition_cipher;
   import btc_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int LIMIT_CYCLES  = 400000;
   localparam int MAX_REPORTS   = 10;

   typedef struct {
      logic [CHAR_W-1:0] ch;
      logic              last;
   } char_txn_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   btc_req_if req_bus ();
   btc_rsp_if rsp_bus ();

   block_transposition_cipher dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // shadow copy of the block's registers and cell store
   logic [DIMREG_W-1:0] rows_reg;
   logic [DIMREG_W-1:0] cols_reg;
   logic                mode_reg;
   logic [PAD_W-1:0]    pad_reg;
   logic [CHAR_W-1:0]   block_cells [CELL_DEPTH];
   logic [CNT_W-1:0]    fill_count;

   out_type      expected_chars [$];
   char_txn_type pending_chars [$];
   char_txn_type next_char;
   out_type      got_char;
   out_type      want_char;

   int   send_idle_pct  = 22;
   int   recv_idle_pct  = 50;
   int   chars_queued   = 0;
   int   chars_accepted = 0;
   int   mismatches     = 0;
   int   cycle_count    = 0;
   logic req_taken      = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int clamp_dim(input logic [DIMREG_W-1:0] v, input int maxv);
      int d;
      d = int'(v);
      if (d == 0) begin
         d = 1;
      end else if (d > maxv) begin
         d = maxv;
      end
      return d;
   endfunction

   // store one byte; when the block completes, queue its read-out order
   task automatic transpose_char(input logic [CHAR_W-1:0] ch, input logic last);
      int      nr;
      int      nc;
      int      size;
      int      pos;
      int      k;
      out_type r;
      nr   = clamp_dim(rows_reg, MAX_ROWS);
      nc   = clamp_dim(cols_reg, MAX_COLS);
      size = nr * nc;
      pos  = int'(fill_count);
      // a shrunk block takes the byte into its last cell
      if (pos >= size) begin
         pos = size - 1;
      end
      block_cells[pos] = ch;
      fill_count = CNT_W'(pos + 1);
      if (pos + 1 < size && !last) begin
         return;
      end
      for (k = pos + 1; k < size; k++) begin
         block_cells[k] = pad_reg;
      end
      for (k = 0; k < size; k++) begin
         if (mode_reg == MODE_ENCODE) begin
            r.char_out = block_cells[(k % nr) * nc + k / nr];
         end else begin
            r.char_out = block_cells[(k % nc) * nr + k / nc];
         end
         r.block_end   = (k == size - 1);
         r.message_end = (k == size - 1) && last;
         expected_chars.push_back(r);
      end
      fill_count = '0;
   endtask

   task automatic flag_mismatch(input string what, input out_type want, input out_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("%s: expected char %02h block_end %0b message_end %0b,",
                  what, want.char_out, want.block_end, want.message_end);
         $display("   got char %02h block_end %0b message_end %0b",
                  got.char_out, got.block_end, got.message_end);
      end
   endtask

   // monitor: register writes, accepted bytes and returned bytes
   always @(posedge clock) begin
      if (reset) begin
         rows_reg   = DIMREG_W'(1);
         cols_reg   = DIMREG_W'(1);
         mode_reg   = MODE_ENCODE;
         pad_reg    = '0;
         fill_count = '0;
         req_taken  = 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_ROWS: rows_reg = csr_wr_data[DIMREG_W-1:0];
               REG_COLS: cols_reg = csr_wr_data[DIMREG_W-1:0];
               REG_MODE: mode_reg = csr_wr_data[0];
               REG_PAD:  pad_reg  = csr_wr_data[PAD_W-1:0];
               default: ;
            endcase
         end
         req_taken = req_bus.valid && req_bus.ready;
         if (req_taken) begin
            transpose_char(req_bus.char_in, req_bus.last_in);
            chars_accepted++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got_char.char_out    = rsp_bus.char_out;
            got_char.block_end   = rsp_bus.block_end;
            got_char.message_end = rsp_bus.message_end;
            if (expected_chars.size() == 0) begin
               flag_mismatch("unexpected transaction", '0, got_char);
            end else begin
               want_char = expected_chars.pop_front();
               if (got_char !== want_char) begin
                  flag_mismatch("mismatch", want_char, got_char);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   // driver: a held transaction moves on only once it was taken
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (!req_bus.valid || req_taken) begin
            if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_char = pending_chars.pop_front();
               req_bus.valid   <= 1'b1;
               req_bus.char_in <= next_char.ch;
               req_bus.last_in <= next_char.last;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic queue_char(input logic [CHAR_W-1:0] ch, input logic last);
      char_txn_type t;
      t.ch   = ch;
      t.last = last;
      pending_chars.push_back(t);
      chars_queued++;
   endtask

   // returns at a falling edge once everything sent has come back
   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (chars_accepted != chars_queued || expected_chars.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // called at a falling edge; the write enable stays up across the four writes
   task automatic set_config(input logic [CSR_DATA_W-1:0] rows_v,
                             input logic [CSR_DATA_W-1:0] cols_v,
                             input logic [CSR_DATA_W-1:0] mode_v,
                             input logic [CSR_DATA_W-1:0] pad_v);
      csr_wr_en   <= 1'b1;
      csr_index   <= REG_ROWS;
      csr_wr_data <= rows_v;
      @(negedge clock);
      csr_index   <= REG_COLS;
      csr_wr_data <= cols_v;
      @(negedge clock);
      csr_index   <= REG_MODE;
      csr_wr_data <= mode_v;
      @(negedge clock);
      csr_index   <= REG_PAD;
      csr_wr_data <= pad_v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // mostly small blocks, now and then zero, saturating or full-size dimensions
   function automatic logic [DIMREG_W-1:0] pick_dim();
      logic [DIMREG_W-1:0] d;
      int                  r;
      r = $urandom_range(9);
      if (r < 7) begin
         d = DIMREG_W'($urandom_range(1, 4));
      end else if (r == 7) begin
         case ($urandom_range(2))
            0:       d = DIMREG_W'(0);
            1:       d = DIMREG_W'(8);
            default: d = DIMREG_W'(15);
         endcase
      end else begin
         d = DIMREG_W'($urandom_range(15));
      end
      return d;
   endfunction

   task automatic random_burst(input int n_chars);
      logic [CSR_DATA_W-1:0] rows_v;
      logic [CSR_DATA_W-1:0] cols_v;
      int                    size;
      int                    msg_len;
      int                    k;
      rows_v = {4'($urandom_range(15)), pick_dim()};
      cols_v = {4'($urandom_range(15)), pick_dim()};
      set_config(rows_v, cols_v, {7'b0, 1'($urandom_range(1))}, 8'($urandom_range(255)));
      size = clamp_dim(rows_v[DIMREG_W-1:0], MAX_ROWS)
           * clamp_dim(cols_v[DIMREG_W-1:0], MAX_COLS);
      while (n_chars > 0) begin
         msg_len = ($urandom_range(9) == 0) ? $urandom_range(1, 3)
                                            : $urandom_range(1, size + 3);
         // an occasional message loses its end marker and runs into the next
         for (k = 0; k < msg_len; k++) begin
            queue_char(8'($urandom_range(255)), (k == msg_len - 1) && ($urandom_range(7) != 0));
         end
         n_chars -= msg_len;
      end
   endtask

   initial begin
      int burst;
      int k;
      clock           = 1'b0;
      reset           = 1'b1;
      csr_wr_en       = 1'b0;
      csr_index       = REG_ROWS;
      csr_wr_data     = '0;
      req_bus.valid   = 1'b0;
      req_bus.char_in = '0;
      req_bus.last_in = 1'b0;
      rsp_bus.ready   = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // 1x1 encode out of reset
      queue_char(8'h00, 1'b0);
      queue_char(8'hFF, 1'b1);
      wait_drained();

      // zero rows read as one, cols above max saturate; short message padded
      set_config(8'hF0, 8'h0F, {7'b0, MODE_DECODE}, 8'h5A);
      queue_char(8'h11, 1'b0);
      queue_char(8'h22, 1'b0);
      queue_char(8'h33, 1'b1);
      wait_drained();

      // a full 3x2 block, then a partial one left open
      set_config(8'h03, 8'h02, {7'b0, MODE_ENCODE}, 8'hFF);
      for (k = 0; k < 8; k++) begin
         queue_char(8'hA0 + 8'(k), 1'b0);
      end
      wait_drained();

      // mode flipped while the block holds two of its six cells
      set_config(8'h03, 8'h02, {7'b0, MODE_DECODE}, 8'hFF);
      queue_char(8'hC3, 1'b1);
      wait_drained();

      // block shrunk below the fill count
      set_config(8'h03, 8'h03, {7'b0, MODE_ENCODE}, 8'h00);
      for (k = 0; k < 5; k++) begin
         queue_char(8'h40 + 8'(k), 1'b0);
      end
      wait_drained();
      set_config(8'h01, 8'h03, {7'b0, MODE_ENCODE}, 8'h00);
      queue_char(8'hD7, 1'b0);
      wait_drained();

      // largest block, nearly all padding
      set_config(8'h0C, 8'hA8, {7'b0, MODE_ENCODE}, 8'h3C);
      queue_char(8'h5E, 1'b1);
      wait_drained();

      for (burst = 0; burst < 9; burst++) begin
         if (burst == 3) begin
            send_idle_pct = 50;
            recv_idle_pct = 22;
         end else if (burst == 6) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         random_burst(7);
         wait_drained();
      end

      if (mismatches == 0 && expected_chars.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
